@@ src/drhd_pkg.sv @@
// shared types, constants and table helpers for the dual room heat damper control unit
// no dependencies; imported by every module of the block
package drhd_pkg;

	localparam int unsigned ADC_BITS_DEF = 10;
	localparam int unsigned PWM_TOP_DEF  = 255;

	localparam int unsigned CODE_W    = 10;
	localparam int unsigned TARGET_W  = 6;
	localparam int unsigned MARGIN_W  = 7;
	localparam int unsigned PCT_W     = 7;
	localparam int unsigned CMP_W     = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 7;

	localparam logic [TARGET_W-1:0] TARGET_RST = 6'd25;
	localparam logic [MARGIN_W-1:0] MARGIN_RST = 7'd10;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_MARGIN = 2'd1;

	localparam logic [1:0] STAGE_OFF  = 2'd0;
	localparam logic [1:0] STAGE_LOW  = 2'd1;
	localparam logic [1:0] STAGE_HIGH = 2'd2;

	// unsigned temperature before offset fits 26 bits, signed error term 28 bits
	localparam int unsigned UW = 26;
	localparam int unsigned EW = 28;
	localparam longint unsigned GAIN_NUM   = 65868;
	localparam longint unsigned GAIN_DEN   = 100;
	localparam longint unsigned OFFSET_Q16 = 19870515;

	typedef struct packed {
		logic [CODE_W-1:0] adc_room1_code;
		logic [CODE_W-1:0] adc_room2_code;
	} sample_t;

	typedef struct packed {
		logic [1:0]       heater_stage;
		logic             stage_one_on;
		logic             stage_two_on;
		logic [PCT_W-1:0] damper1_percent;
		logic [PCT_W-1:0] damper2_percent;
		logic [CMP_W-1:0] damper1_compare;
		logic [CMP_W-1:0] damper2_compare;
	} result_t;

	typedef struct packed {
		logic             below_hi;
		logic             below_lo;
		logic [PCT_W-1:0] pct;
	} lane_res_t;

	typedef logic [(1 << PCT_W)-1:0][CMP_W-1:0] cmp_tbl_t;

	function automatic cmp_tbl_t cmp_table(input int unsigned top);
		cmp_tbl_t t;
		for (int unsigned p = 0; p < (1 << PCT_W); p++) begin
			t[p] = CMP_W'((p * top) / 100);
		end
		return t;
	endfunction

endpackage

@@ src/drhd_lane.sv @@
// one room lane: code to fixed-point temperature, heat thresholds and raw damper percent
// constant divide is split into a quotient product and a reciprocal multiply on the remainder
// depends on drhd_pkg
module drhd_lane #(
	parameter int unsigned ADC_BITS = drhd_pkg::ADC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            adv,
	input  logic [ADC_BITS-1:0]             code,
	input  logic [drhd_pkg::TARGET_W-1:0]   target_temp,
	output drhd_pkg::lane_res_t             res
);
	import drhd_pkg::*;

	localparam longint unsigned FS  = (64'd1 << ADC_BITS) - 64'd1;
	localparam longint unsigned DEN = GAIN_DEN * FS;
	localparam longint unsigned NUM = GAIN_NUM * 64'd65536;
	localparam longint unsigned QN  = NUM / DEN;
	localparam longint unsigned RN  = NUM % DEN;
	localparam int unsigned QNW = $clog2(QN + 1);
	localparam int unsigned DW  = $clog2(DEN + 1);
	localparam int unsigned BW  = ADC_BITS + QNW;
	localparam int unsigned RW  = ADC_BITS + DW;
	localparam int unsigned SH  = RW + DW;
	localparam longint unsigned RCP = ((64'd1 << SH) + DEN - 64'd1) / DEN;
	localparam int unsigned RCW = $clog2(RCP + 1);
	localparam int unsigned PW  = RW + RCW;
	localparam logic [QNW-1:0] QN_C  = QNW'(QN);
	localparam logic [DW-1:0]  RN_C  = DW'(RN);
	localparam logic [RCW-1:0] RCP_C = RCW'(RCP);

	logic [BW-1:0] base_s1;
	logic [RW-1:0] rem_s1;

	logic [PW-1:0]       prod;
	logic [ADC_BITS-1:0] quo;
	logic [BW-1:0]       base_s2;
	logic [ADC_BITS-1:0] quo_s2;

	lane_res_t res_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			base_s1 <= {{QNW{1'b0}}, code} * {{ADC_BITS{1'b0}}, QN_C};
			rem_s1  <= {{DW{1'b0}}, code} * {{ADC_BITS{1'b0}}, RN_C};
		end
	end

	// remainder over the constant by reciprocal multiply, exact for every remainder below 2^RW
	assign prod = {{RCW{1'b0}}, rem_s1} * {{RW{1'b0}}, RCP_C};
	assign quo  = prod[SH +: ADC_BITS];

	always_ff @(posedge clk) begin
		if (adv) begin
			base_s2 <= base_s1;
			quo_s2  <= quo;
		end
	end

	logic [BW:0]           usum;
	logic [UW-1:0]         u;
	logic signed [EW-1:0]  err;
	logic [EW-1:0]         rnd;
	lane_res_t             res_d;

	// err is target minus temperature, both in q16
	always_comb begin
		usum = (BW+1)'(base_s2) + (BW+1)'(quo_s2);
		u    = UW'(usum);
		err  = $signed(EW'({target_temp, 16'h0000})) + $signed(EW'(OFFSET_Q16))
			- $signed(EW'(u));
		rnd  = EW'(err) + EW'(32'd8192);
		res_d.below_hi = (err > $signed(EW'(32'd65536)));
		res_d.below_lo = (err > $signed(EW'(32'd32768)));
		if (err <= $signed(EW'(0))) begin
			res_d.pct = '0;
		end else if (err >= $signed(EW'(32'd1638400))) begin
			res_d.pct = PCT_W'(100);
		end else begin
			res_d.pct = rnd[14 +: PCT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s3 <= res_d;
		end
	end

	assign res = res_s3;

endmodule

@@ src/drhd_merge.sv @@
// merging stage: heater stage from both lanes, duty smoothing state, compare lookup
// holds the output register of the block; depends on drhd_pkg
module drhd_merge #(
	parameter int unsigned PWM_TOP = drhd_pkg::PWM_TOP_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          vld,
	input  drhd_pkg::lane_res_t           lane1,
	input  drhd_pkg::lane_res_t           lane2,
	input  logic [drhd_pkg::MARGIN_W-1:0] smooth_margin,
	output drhd_pkg::result_t             result,
	output logic                          result_valid
);
	import drhd_pkg::*;

	localparam cmp_tbl_t CMP_TBL = cmp_table(PWM_TOP);

	logic [PCT_W-1:0] prev1_q;
	logic [PCT_W-1:0] prev2_q;
	logic             valid_q;
	result_t          res_q;

	logic [PCT_W-1:0] p1;
	logic [PCT_W-1:0] p2;
	logic [1:0]       stage;
	result_t          res_d;

	function automatic logic [PCT_W-1:0] smooth(input logic [PCT_W-1:0] prev,
		input logic [PCT_W-1:0] cur, input logic [MARGIN_W-1:0] m);
		logic [PCT_W:0] hi;
		logic [PCT_W:0] lo;
		logic [PCT_W:0] sum;
		hi  = {1'b0, prev} + {1'b0, m};
		lo  = {1'b0, cur} + {1'b0, m};
		sum = {1'b0, prev} + {1'b0, cur};
		if (({1'b0, cur} > hi) || (lo < {1'b0, prev})) begin
			return sum[PCT_W:1];
		end
		return cur;
	endfunction

	always_comb begin
		if (lane1.below_hi && lane2.below_hi) begin
			stage = STAGE_HIGH;
		end else if (lane1.below_lo || lane2.below_lo) begin
			stage = STAGE_LOW;
		end else begin
			stage = STAGE_OFF;
		end
		p1 = smooth(prev1_q, lane1.pct, smooth_margin);
		p2 = smooth(prev2_q, lane2.pct, smooth_margin);
		res_d.heater_stage    = stage;
		res_d.stage_one_on    = (stage == STAGE_LOW);
		res_d.stage_two_on    = (stage == STAGE_HIGH);
		res_d.damper1_percent = p1;
		res_d.damper2_percent = p2;
		res_d.damper1_compare = CMP_TBL[p1];
		res_d.damper2_compare = CMP_TBL[p2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			prev1_q <= '0;
			prev2_q <= '0;
		end else if (adv) begin
			valid_q <= vld;
			if (vld) begin
				prev1_q <= p1;
				prev2_q <= p2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign result       = res_q;
	assign result_valid = valid_q;

endmodule

@@ src/dual_room_heat_damper_control_unit.sv @@
// Dual room heat damper control unit, top level.
// Each sample transaction carries one ADC code per room; each result transaction
// carries the heater stage, its two enables, and per room a smoothed damper percent
// and its PWM compare value.
// Channels use valid/stall: a transaction moves on a rising edge with valid high and
// stall low. Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data):
// index 0 is the target temperature, index 1 the smoothing margin, others are ignored.
// The pipeline has four register stages: the code products, the reciprocal multiply, the
// temperature stage in each room lane and the merge output register. A new sample is
// taken every cycle unless the pipeline is held by a stall.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// sample_stall goes high in the same cycle; nothing is dropped.
// Reset clears all valid bits, both previous duty values, and sets the target to
// 25 C and the margin to 10.
// Depends on drhd_pkg, drhd_lane and drhd_merge.
module dual_room_heat_damper_control_unit #(
	parameter int unsigned ADC_BITS = drhd_pkg::ADC_BITS_DEF,
	parameter int unsigned PWM_TOP  = drhd_pkg::PWM_TOP_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  drhd_pkg::sample_t              sample,
	output logic                           result_valid,
	input  logic                           result_stall,
	output drhd_pkg::result_t              result,
	input  logic                           cfg_wr_en,
	input  logic [drhd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [drhd_pkg::CFG_DAT_W-1:0] cfg_data
);
	import drhd_pkg::*;

	localparam int unsigned LAT = 3;

	logic [TARGET_W-1:0] target_q;
	logic [MARGIN_W-1:0] margin_q;
	logic [LAT-1:0]      vld_q;
	logic                adv;
	logic                acc;
	lane_res_t           lane1;
	lane_res_t           lane2;

	assign adv          = !(result_valid && result_stall);
	assign sample_stall = !adv;
	assign acc          = sample_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
			margin_q <= MARGIN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TARGET_TEMP:   target_q <= cfg_data[TARGET_W-1:0];
				CFG_SMOOTH_MARGIN: margin_q <= cfg_data[MARGIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], acc};
		end
	end

	drhd_lane #(.ADC_BITS(ADC_BITS)) u_lane1 (
		.clk         (clk),
		.adv         (adv),
		.code        (ADC_BITS'(sample.adc_room1_code)),
		.target_temp (target_q),
		.res         (lane1)
	);

	drhd_lane #(.ADC_BITS(ADC_BITS)) u_lane2 (
		.clk         (clk),
		.adv         (adv),
		.code        (ADC_BITS'(sample.adc_room2_code)),
		.target_temp (target_q),
		.res         (lane2)
	);

	drhd_merge #(.PWM_TOP(PWM_TOP)) u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.vld           (vld_q[LAT-1]),
		.lane1         (lane1),
		.lane2         (lane2),
		.smooth_margin (margin_q),
		.result        (result),
		.result_valid  (result_valid)
	);

endmodule
